>>> sv/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with put-back and search.
// Used by brf_front, brf_back, the top level byte_ring_fifo_with_unget_and_search and its testbench.
// No dependencies.
`default_nettype none

package brf_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int MAX_PATTERN_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int FILL_W      = 9;
  localparam int PAT_W       = 64;
  localparam int PLEN_W      = 4;

  // Register indexes of the configuration channel.
  localparam logic CFG_PATTERN = 1'b0;
  localparam logic CFG_LEN     = 1'b1;

  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_PUT_BACK = 2'd1,
    REQ_DROP     = 2'd2,
    REQ_SEARCH   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TOO_FEW   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DROP_RD,
    BK_SEARCH,
    BK_HOLD
  } bk_state_t;

  typedef struct packed {
    req_kind_t    kind;
    logic [7:0]   data_byte;
    logic [8:0]   drop_count;
    logic [7:0]   start_offset;
  } cmd_t;

  typedef struct packed {
    status_t      status;
    logic         found;
    logic [7:0]   match_offset;
    logic [8:0]   fill_level;
    logic         is_full;
    logic [7:0]   head_byte;
  } res_t;

  typedef struct packed {
    logic [PLEN_W-1:0] len;
    logic [PAT_W-1:0]  bytes;
  } pat_cfg_t;

endpackage

`default_nettype wire

>>> sv/byte_ring_fifo_with_unget_and_search.sv
// Circular byte FIFO with put-back at the head, bulk drop and pattern search.
//
// Requests arrive as beats on the in_ stream: in_tuser carries the request kind
// (push at tail, put back at head, drop from head, search) and in_tdata its operands.
// Every request beat yields exactly one result beat on the out_ stream, in order.
// The result carries a status in out_tuser, and the search outcome, fill level,
// full flag and current head byte in out_tdata. The search pattern and its length
// are written through the cfg_ channel, which is always ready; write it only while
// no request is outstanding.
//
// A request beat is written into a two-entry command queue, and the executor takes
// it from there. Push, put-back, refused requests and searches that cannot match are
// done in a single executor step that writes the output register. A drop that leaves
// bytes behind goes through the BK_DROP_RD state, since the new head byte comes from
// the store's registered read port. A search reads one held byte per cycle through
// that port, over at most DEPTH bytes per request.
//
// Reset empties the store and clears the pattern; the byte store itself is not
// cleared and needs no clearing pass. When the receiver stalls, the result waits in
// the output register, the executor holds, the queue fills and in_tready drops.
`default_nettype none

module byte_ring_fifo_with_unget_and_search
  import brf_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [7:0] data_byte, [16:8] drop_count, [24:17] start_offset, [31:25] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]             in_tuser,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] found, [8:1] match_offset, [17:9] fill_level, [18] is_full,
  // [26:19] head_byte, [31:27] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [1:0] status
  output logic [1:0]                  out_tuser,
  // Configuration writes: index 0 is pattern_bytes, index 1 is pattern_len.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [PAT_W-1:0]       cfg_data
);

  pat_cfg_t cfg_r, cfg_nxt;
  logic     cmd_valid;
  logic     cmd_pop;
  cmd_t     cmd;
  res_t     res;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN: cfg_nxt.bytes = cfg_data;
        CFG_LEN:     cfg_nxt.len   = cfg_data[PLEN_W-1:0];
        default:     cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  brf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  brf_back #(
    .DEPTH       (DEPTH),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  // Pack the result beat, highest field first.
  assign out_tdata = {
    (OUT_TDATA_W - 27)'(0),
    res.head_byte,
    res.is_full,
    res.fill_level,
    res.match_offset,
    res.found
  };
  assign out_tuser = res.status;

  // A reported match always comes with an ok status.
  a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.found |-> res.status == ST_OK)
    else $error("found result without ok status");

  // A miss carries no match position.
  a_miss_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.status == ST_NOT_FOUND |-> !res.found && res.match_offset == 8'd0)
    else $error("not-found result carries match data");

  // A refusal for lack of room must report a full store.
  a_full_refusal : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.status == ST_FULL |-> res.is_full)
    else $error("full refusal while store not full");

endmodule

`default_nettype wire

>>> sv/brf_front.sv
// Front end: takes request beats, decodes them into commands and queues them.
// Depends on brf_pkg.
`default_nettype none

module brf_front
  import brf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [1:0]            in_tuser,
  output logic                       cmd_valid,
  output cmd_t                       cmd,
  input  wire logic                  cmd_pop
);

  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [QIW-1:0]   wr_r, wr_nxt;
  logic [QIW-1:0]   rd_r, rd_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  cmd_t             in_cmd;
  logic             push;

  always_comb begin
    in_cmd.kind         = req_kind_t'(in_tuser);
    in_cmd.data_byte    = in_tdata[7:0];
    in_cmd.drop_count   = in_tdata[16:8];
    in_cmd.start_offset = in_tdata[24:17];
  end

  assign in_tready = (cnt_r != QCW'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_nxt = (rd_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

>>> sv/brf_back.sv
// Back end: byte store, ring pointers, pattern search walker and result register.
// Depends on brf_pkg.
`default_nettype none

module brf_back
  import brf_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  input  wire cmd_t     cmd,
  output logic          cmd_pop,
  input  wire pat_cfg_t cfg,
  output logic          out_valid,
  output res_t          out_res,
  input  wire logic     out_ready
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > FILL_W) ? CW : FILL_W;
  localparam int PW = $clog2(MAX_PATTERN + 1);

  logic [7:0]      mem [DEPTH];
  logic [7:0]      rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  bk_state_t       state_r, state_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [7:0]      head_r, head_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic [CW-1:0]   rd_off_r, rd_off_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [PW-1:0]   seen_r, seen_nxt;
  logic [7:0]      win_r [MAX_PATTERN];
  logic [7:0]      win_nxt [MAX_PATTERN];
  logic [7:0]      win_cur [MAX_PATTERN];
  res_t            res_r, res_nxt;
  res_t            out_r, out_nxt;
  logic            out_vld_r, out_vld_nxt;

  logic [PW-1:0]   plen;
  logic [PW-1:0]   seen_cur;
  logic            all_eq;
  logic            out_free;
  logic            emit, from_hold;
  status_t         st;
  logic            fnd;
  logic [CW-1:0]   moff;
  res_t            res_new;
  logic [WW-1:0]   cnt_w;
  logic [WW:0]     srch_end;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW:0]   off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign plen = (cfg.len > PLEN_W'(MAX_PATTERN)) ? PW'(MAX_PATTERN) : PW'(cfg.len);
  assign seen_cur = (seen_r == PW'(MAX_PATTERN)) ? seen_r : seen_r + 1'b1;
  assign out_free = !out_vld_r || out_ready;
  assign cnt_w    = WW'(cmd.drop_count);
  assign srch_end = (WW+1)'(cmd.start_offset) + (WW+1)'(plen);

  // Window of the most recent bytes, newest in slot 0.
  always_comb begin
    win_cur[0] = rd_data_r;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_cur[k] = win_r[k-1];
    end
  end

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(plen)) begin
        if (win_cur[int'(plen) - 1 - i] != cfg.bytes[8*i +: 8]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    head_nxt   = head_r;
    iss_nxt    = iss_r;
    rd_off_nxt = rd_off_r;
    rd_vld_nxt = 1'b0;
    seen_nxt   = seen_r;
    win_nxt    = win_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    out_vld_nxt = out_vld_r && !out_ready;
    mem_we     = 1'b0;
    mem_waddr  = wp_r;
    mem_wdata  = cmd.data_byte;
    mem_re     = 1'b0;
    mem_raddr  = rp_r;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    from_hold  = 1'b0;
    st         = ST_OK;
    fnd        = 1'b0;
    moff       = '0;

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            REQ_PUSH: begin
              emit = 1'b1;
              if (fill_r == CW'(DEPTH)) begin
                st = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wp_r;
                wp_nxt    = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
                fill_nxt  = fill_r + 1'b1;
                if (fill_r == '0) begin
                  head_nxt = cmd.data_byte;
                end
              end
            end
            REQ_PUT_BACK: begin
              emit = 1'b1;
              if (fill_r == CW'(DEPTH)) begin
                st = ST_FULL;
              end else begin
                rp_nxt    = (rp_r == '0) ? AW'(DEPTH - 1) : rp_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = rp_nxt;
                fill_nxt  = fill_r + 1'b1;
                head_nxt  = cmd.data_byte;
              end
            end
            REQ_DROP: begin
              if (cnt_w > WW'(fill_r)) begin
                emit = 1'b1;
                st   = ST_TOO_FEW;
              end else if (cnt_w == '0) begin
                emit = 1'b1;
              end else if (cnt_w == WW'(fill_r)) begin
                // Emptied: pointers go back to the start of the ring.
                emit     = 1'b1;
                rp_nxt   = '0;
                wp_nxt   = '0;
                fill_nxt = '0;
              end else begin
                rp_nxt    = wrap_add(rp_r, (AW+1)'(cnt_w));
                fill_nxt  = fill_r - CW'(cnt_w);
                mem_re    = 1'b1;
                mem_raddr = rp_nxt;
                state_nxt = BK_DROP_RD;
              end
            end
            default: begin
              if (plen == '0 || srch_end > (WW+1)'(fill_r)) begin
                emit = 1'b1;
                st   = ST_NOT_FOUND;
              end else begin
                iss_nxt   = CW'(cmd.start_offset);
                seen_nxt  = '0;
                state_nxt = BK_SEARCH;
              end
            end
          endcase
        end
      end

      BK_DROP_RD: begin
        head_nxt = rd_data_r;
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end

      BK_SEARCH: begin
        if (rd_vld_r) begin
          win_nxt  = win_cur;
          seen_nxt = seen_cur;
        end
        if (rd_vld_r && seen_cur >= plen && all_eq) begin
          fnd  = 1'b1;
          moff = rd_off_r + 1'b1 - CW'(plen);
        end else if (rd_vld_r && rd_off_r == CW'(fill_r - 1'b1)) begin
          st = ST_NOT_FOUND;
        end else begin
          if (iss_r < fill_r) begin
            mem_re     = 1'b1;
            mem_raddr  = wrap_add(rp_r, (AW+1)'(iss_r));
            iss_nxt    = iss_r + 1'b1;
            rd_off_nxt = iss_r;
            rd_vld_nxt = 1'b1;
          end
        end
        if (fnd || st == ST_NOT_FOUND) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_HOLD;
          end
        end
      end

      BK_HOLD: begin
        if (out_free) begin
          emit      = 1'b1;
          from_hold = 1'b1;
          state_nxt = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    res_new.status       = st;
    res_new.found        = fnd;
    res_new.match_offset = 8'(moff);
    res_new.fill_level   = FILL_W'(fill_nxt);
    res_new.is_full      = (fill_nxt == CW'(DEPTH));
    res_new.head_byte    = (fill_nxt == '0) ? 8'd0 : head_nxt;

    if (state_r == BK_SEARCH) begin
      res_nxt = res_new;
    end
    if (emit) begin
      out_nxt     = from_hold ? res_r : res_new;
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      rp_r      <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r   <= head_nxt;
    iss_r    <= iss_nxt;
    rd_off_r <= rd_off_nxt;
    seen_r   <= seen_nxt;
    win_r    <= win_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

>>> dv/tb_byte_ring_fifo_with_unget_and_search.sv
`timescale 1ns / 100ps
// Self-checking testbench for byte_ring_fifo_with_unget_and_search: request beats
// from a queue, a ring predictor that answers each accepted beat, and an in-order check.
// Depends on brf_pkg and the top level byte_ring_fifo_with_unget_and_search.

module tb_byte_ring_fifo_with_unget_and_search;
  import brf_pkg::*;

  localparam int RING_DEPTH   = DEPTH_DEF;
  localparam int MAX_PAT      = MAX_PATTERN_DEF;
  // The limit is meant to cover the slowest legal run: every beat a full-ring search,
  // each with the longest receiver stall and the longest sender gap on top.
  localparam int CYCLE_LIMIT  = 1500000;
  // A search over a full ring is the longest a single request can take.
  localparam int SETTLE_TICKS = RING_DEPTH + 40;
  localparam int RAND_PER_PH  = 70;
  localparam int NUM_PHASES   = 7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // [7:0] data_byte, [16:8] drop_count, [24:17] start_offset, [31:25] zero
  logic [31:0]       in_tdata = '0;
  // [1:0] req_type
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // [0] found, [8:1] match_offset, [17:9] fill_level, [18] is_full,
  // [26:19] head_byte, [31:27] zero
  logic [31:0]       out_tdata;
  // [1:0] status
  logic [1:0]        out_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_PATTERN;
  logic [PAT_W-1:0]  cfg_data = '0;

  byte_ring_fifo_with_unget_and_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor. It keeps its own copy of the byte ring, the two pointers, the
  // empty flag and the search pattern, and is advanced once per accepted beat.
  // ---------------------------------------------------------------------------
  logic [7:0]        ring_mem [0:RING_DEPTH-1];
  int unsigned       head_idx = 0;
  int unsigned       tail_idx = 0;
  bit                ring_empty = 1'b1;
  logic [PAT_W-1:0]  pat_bytes_q = '0;
  logic [PLEN_W-1:0] pat_len_q = '0;

  function automatic int unsigned ring_level();
    if (ring_empty) return 0;
    if (tail_idx > head_idx) return tail_idx - head_idx;
    return RING_DEPTH - head_idx + tail_idx;
  endfunction

  function automatic res_t predict_ring_answer(cmd_t c);
    res_t        r;
    int unsigned lvl, plen, p, i;
    bit          hit;
    r = '0;
    r.status = ST_OK;
    lvl = ring_level();
    case (c.kind)
      REQ_PUSH: begin
        if (lvl >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[tail_idx] = c.data_byte;
          tail_idx = (tail_idx + 1) % RING_DEPTH;
          ring_empty = 1'b0;
        end
      end
      REQ_PUT_BACK: begin
        if (lvl >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_idx = (head_idx + RING_DEPTH - 1) % RING_DEPTH;
          ring_mem[head_idx] = c.data_byte;
          ring_empty = 1'b0;
        end
      end
      REQ_DROP: begin
        if (c.drop_count > lvl) begin
          r.status = ST_TOO_FEW;
        end else if (c.drop_count != 0) begin
          head_idx = (head_idx + c.drop_count) % RING_DEPTH;
          // Emptying the ring sends both pointers back to the bottom.
          if (c.drop_count == lvl) begin
            ring_empty = 1'b1;
            head_idx = 0;
            tail_idx = 0;
          end
        end
      end
      REQ_SEARCH: begin
        // A length beyond the pattern register's span is clipped to its span.
        plen = (pat_len_q > MAX_PAT) ? MAX_PAT : pat_len_q;
        r.status = ST_NOT_FOUND;
        if (plen > 0 && lvl >= plen) begin
          // A match has to lie wholly inside the held bytes.
          for (p = c.start_offset; p + plen <= lvl && !r.found; p++) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++) begin
              if (ring_mem[(head_idx + p + i) % RING_DEPTH] != pat_bytes_q[8*i +: 8]) begin
                hit = 1'b0;
              end
            end
            if (hit) begin
              r.status = ST_OK;
              r.found = 1'b1;
              r.match_offset = p[7:0];
            end
          end
        end
      end
    endcase
    lvl = ring_level();
    r.fill_level = lvl[8:0];
    r.is_full = (lvl >= RING_DEPTH);
    r.head_byte = ring_empty ? 8'h00 : ring_mem[head_idx];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request plan. The stimulus code fills pending_reqs ahead of time and keeps a
  // shadow of the fill level so that drops and searches can be aimed.
  // ---------------------------------------------------------------------------
  cmd_t              pending_reqs [$];
  res_t              awaited_answers [$];
  int unsigned       total_queued = 0;
  int unsigned       accepted_cnt = 0;
  int unsigned       plan_level = 0;
  logic [PAT_W-1:0]  plan_pat = '0;
  int unsigned       plan_len = 0;

  task automatic queue_req(req_kind_t k, logic [7:0] d, logic [8:0] n, logic [7:0] s);
    cmd_t c;
    c.kind = k;
    c.data_byte = d;
    c.drop_count = n;
    c.start_offset = s;
    pending_reqs.push_back(c);
    total_queued++;
    case (k)
      REQ_PUSH, REQ_PUT_BACK: if (plan_level < RING_DEPTH) plan_level++;
      REQ_DROP: if (n <= plan_level) plan_level -= n;
      default: ;
    endcase
  endtask

  // Fields that a request kind does not use still carry random values.
  function automatic logic [8:0] any_count();
    return 9'($urandom_range(0, 256));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_push(logic [7:0] d);
    queue_req(REQ_PUSH, d, any_count(), any_byte());
  endtask

  // Pushes the first n bytes of the current pattern, so that searches can hit.
  task automatic queue_pattern(int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) queue_push(plan_pat[8*(i % MAX_PAT) +: 8]);
  endtask

  task automatic queue_search(logic [7:0] s);
    queue_req(REQ_SEARCH, any_byte(), any_count(), s);
  endtask

  task automatic queue_drop(logic [8:0] n);
    queue_req(REQ_DROP, any_byte(), n, any_byte());
  endtask

  // Mostly well-formed traffic around a modest fill level, with pattern runs so
  // that searches succeed, and some refused and out-of-range requests mixed in.
  task automatic queue_random(int unsigned count);
    int unsigned k, sel, eff, n, lim;
    eff = (plan_len > MAX_PAT) ? MAX_PAT : plan_len;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        queue_push(any_byte());
      end else if (sel < 38) begin
        // Full pattern runs, or one byte short to leave a near miss behind.
        if (eff == 0) begin
          queue_pattern(3);
        end else begin
          queue_pattern((sel[0] && eff > 1) ? eff - 1 : eff);
        end
      end else if (sel < 50) begin
        queue_req(REQ_PUT_BACK, any_byte(), any_count(), any_byte());
      end else if (sel < 68) begin
        case ($urandom_range(0, 9))
          7: n = plan_level;
          8: n = (plan_level < RING_DEPTH) ? plan_level + 1 : RING_DEPTH;
          9: n = $urandom_range(0, 256);
          default: begin
            lim = (plan_level < 6) ? plan_level : 6;
            n = $urandom_range(0, lim);
          end
        endcase
        queue_drop(n[8:0]);
      end else begin
        if (plan_level > 0 && $urandom_range(0, 4) != 0) begin
          queue_search(8'($urandom_range(0, plan_level - 1)));
        end else begin
          queue_search(any_byte());
        end
      end
    end
  endtask

  // Drives the ring to full, with the head wrapped around the bottom of the store
  // and the pattern sitting right at the tail, then probes it and empties it.
  task automatic queue_fill_to_full();
    if (plan_level > 0) queue_drop(plan_level[8:0]);
    repeat (3) queue_req(REQ_PUT_BACK, any_byte(), any_count(), any_byte());
    while (plan_level < RING_DEPTH - MAX_PAT) queue_push(any_byte());
    queue_pattern(MAX_PAT);
    queue_push(any_byte());
    queue_req(REQ_PUT_BACK, any_byte(), any_count(), any_byte());
    queue_search(8'd0);
    queue_search(8'd200);
    queue_search(8'd249);
    queue_search(8'd248);
    queue_search(8'd255);
    queue_drop(9'd0);
    queue_drop(9'd5);
    repeat (2) queue_req(REQ_PUT_BACK, any_byte(), any_count(), any_byte());
    queue_push(any_byte());
    queue_pattern(MAX_PAT);
    queue_search(8'd0);
    queue_drop(9'd256);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Inputs change on the falling edge; the beat is known to be
  // taken from in_fire, which the sampling block sets on the rising edge.
  // ---------------------------------------------------------------------------
  bit          in_fire = 1'b0;
  bit          tx_steady = 1'b0;
  bit          drain_hold = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned beats_sent = 0;
  cmd_t        next_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (drain_hold) begin
        // Hold off until every outstanding answer has come back.
        if (awaited_answers.size() == 0) drain_hold = 1'b0;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        in_tdata <= {7'b0, next_req.start_offset, next_req.drop_count, next_req.data_byte};
        in_tuser <= next_req.kind;
        in_tvalid <= 1'b1;
        beats_sent++;
        if (beats_sent % 250 == 0 || $urandom_range(0, 149) == 0) drain_hold = 1'b1;
        if (!tx_steady) begin
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
          end
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: always ready, randomly ready, or ready with long stalls.
  // ---------------------------------------------------------------------------
  int unsigned rx_mode = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 2) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 40);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sampling on the rising edge: result check first, then prediction for a taken
  // request beat, then any register write.
  // ---------------------------------------------------------------------------
  int unsigned fail_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  res_t        seen_ans;
  res_t        want_ans;
  cmd_t        taken_req;

  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        seen_ans.status = status_t'(out_tuser);
        seen_ans.found = out_tdata[0];
        seen_ans.match_offset = out_tdata[8:1];
        seen_ans.fill_level = out_tdata[17:9];
        seen_ans.is_full = out_tdata[18];
        seen_ans.head_byte = out_tdata[26:19];
        if (awaited_answers.size() == 0) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("[%0t] result beat %0d arrived with nothing outstanding: %p",
                     $realtime, results_seen, seen_ans);
          end
        end else begin
          want_ans = awaited_answers.pop_front();
          if (seen_ans.status !== want_ans.status || seen_ans.found !== want_ans.found ||
              seen_ans.match_offset !== want_ans.match_offset ||
              seen_ans.fill_level !== want_ans.fill_level ||
              seen_ans.is_full !== want_ans.is_full ||
              seen_ans.head_byte !== want_ans.head_byte) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("[%0t] result beat %0d mismatch", $realtime, results_seen);
              $display("  expected status=%0d found=%0d match=%0d fill=%0d full=%0d head=%02h",
                       want_ans.status, want_ans.found, want_ans.match_offset,
                       want_ans.fill_level, want_ans.is_full, want_ans.head_byte);
              $display("  actual   status=%0d found=%0d match=%0d fill=%0d full=%0d head=%02h",
                       seen_ans.status, seen_ans.found, seen_ans.match_offset,
                       seen_ans.fill_level, seen_ans.is_full, seen_ans.head_byte);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        taken_req.kind = req_kind_t'(in_tuser);
        taken_req.data_byte = in_tdata[7:0];
        taken_req.drop_count = in_tdata[16:8];
        taken_req.start_offset = in_tdata[24:17];
        awaited_answers.push_back(predict_ring_answer(taken_req));
        accepted_cnt++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PATTERN) begin
          pat_bytes_q = cfg_data;
        end else begin
          pat_len_q = cfg_data[PLEN_W-1:0];
        end
      end
    end
  end

  // Watchdog on the whole run.
  int unsigned cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_cnt, awaited_answers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase sequencing. Registers are only written once every queued request has
  // been taken and answered, so the block is idle at each write.
  // ---------------------------------------------------------------------------
  task automatic write_cfg(logic idx, logic [PAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pattern(logic [PAT_W-1:0] pat, int unsigned len);
    plan_pat = pat;
    plan_len = len;
    write_cfg(CFG_PATTERN, pat);
    write_cfg(CFG_LEN, PAT_W'(len));
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (!(accepted_cnt == total_queued && awaited_answers.size() == 0));
  endtask

  initial begin
    int ph;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: a two-byte pattern; empty-ring searches and drops, a
    // put-back that wraps the head below zero, hits, misses from a start past
    // the fill level, a partial pattern at the tail, a refused drop and a drop
    // that empties the ring.
    set_pattern(64'h0123_4567_89AB_C35A, 2);
    rx_mode = 1;
    queue_search(8'd0);
    queue_drop(9'd0);
    queue_drop(9'd1);
    queue_drop(9'd256);
    queue_req(REQ_PUT_BACK, 8'hFF, any_count(), any_byte());
    queue_push(8'h00);
    queue_push(8'h5A);
    queue_push(8'hC3);
    queue_search(8'd0);
    queue_search(8'd3);
    queue_search(8'd255);
    queue_push(8'h5A);
    queue_search(8'd3);
    queue_search(8'd2);
    queue_drop(9'd1);
    queue_req(REQ_PUT_BACK, 8'hA5, any_count(), any_byte());
    queue_drop(9'd255);
    queue_drop(9'd5);
    queue_push(8'h5A);
    queue_push(8'hC3);
    queue_search(8'd0);
    queue_req(REQ_PUT_BACK, 8'h80, any_count(), any_byte());
    queue_drop(9'd3);
    wait_quiet();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          set_pattern('1, MAX_PAT);
          rx_mode = 0;
          tx_steady = 1'b1;
        end
        1: begin
          set_pattern('0, 1);
          rx_mode = 2;
          tx_steady = 1'b0;
        end
        2: begin
          // A length above the pattern span, every length bit set.
          set_pattern({$urandom, $urandom}, 15);
          rx_mode = 1;
        end
        3: begin
          set_pattern({$urandom, $urandom}, 0);
          rx_mode = 0;
        end
        4: begin
          set_pattern({$urandom, $urandom}, $urandom_range(2, 7));
          rx_mode = 2;
          tx_steady = 1'b1;
        end
        5: begin
          set_pattern({$urandom, $urandom}, MAX_PAT);
          rx_mode = 1;
          tx_steady = 1'b0;
          queue_fill_to_full();
        end
        default: begin
          set_pattern({$urandom, $urandom}, $urandom_range(9, 14));
          rx_mode = 2;
        end
      endcase
      queue_random((ph == 5) ? RAND_PER_PH / 2 : RAND_PER_PH);
      wait_quiet();
    end

    // Let any stray result beat show up before the verdict.
    repeat (SETTLE_TICKS) @(posedge clk);
    if (awaited_answers.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/brf_pkg.sv
sv/brf_front.sv
sv/brf_back.sv
sv/byte_ring_fifo_with_unget_and_search.sv
dv/tb_byte_ring_fifo_with_unget_and_search.sv
